[hdl/hermite_curve_point_generator_macros.svh]
// Assertion macros shared by the Hermite curve point generator RTL.
`ifndef HERMITE_CURVE_POINT_GENERATOR_MACROS_SVH
`define HERMITE_CURVE_POINT_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HCPG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define HCPG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/hcpg_pkg.sv]
// Shared constants for the Hermite curve point generator.
`timescale 1ns / 1ps

package hcpg_pkg;

	// Default parameter values
	localparam int HCPG_COORD_WIDTH         = 16;
	localparam int HCPG_PARAM_FRACTION_BITS = 16;

	// Packed vector layout: x, y, z signed Q8.8 lanes
	localparam int VEC_W     = 48;
	localparam int LANE_W    = 16;
	localparam int NUM_LANES = 3;
	localparam int NUM_VECS  = 4;

	// Register and field widths
	localparam int NSEG_W     = 10;
	localparam int STEP_W     = 17;
	localparam int COUNT_W    = 11;
	localparam int IDX_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Reset values of the segment count and parameter step
	localparam logic [NSEG_W-1:0] NSEG_RESET = NSEG_W'(50);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1311);

	// Register map
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_START_POINT   = 3'd0;
	localparam cfg_idx_t REG_END_POINT     = 3'd1;
	localparam cfg_idx_t REG_START_TANGENT = 3'd2;
	localparam cfg_idx_t REG_END_TANGENT   = 3'd3;
	localparam cfg_idx_t REG_NUM_SEGMENTS  = 3'd4;
	localparam cfg_idx_t REG_T_STEP        = 3'd5;

endpackage

[hdl/hermite_curve_point_generator.sv]
// Top level of the 3D cubic Hermite curve point generator.
`timescale 1ns / 1ps
`include "hermite_curve_point_generator_macros.svh"

// Each tick transaction (restart low) yields one curve point
// B0*P0 + B1*P1 + B2*T0 + B3*T1 at the current parameter t, then advances t
// (clamped at 1.0) and the point index; after num_segments+1 points ticks
// yield nothing until a restart transaction, which clears t and the index.
// A point is computed fully before the next transaction is taken: t*t and
// t2*t run through one bit-serial shift-add multiplier, one multiplier bit
// per cycle, and the three coordinates then accumulate one coordinate bit
// per cycle, MSB first. Restart and finished-curve ticks are handled
// without leaving the idle state. A finished point waits in the output
// register while the next transaction is taken. There is no clearing pass
// after reset.
module hermite_curve_point_generator
	import hcpg_pkg::*;
#(
	parameter int COORD_WIDTH         = HCPG_COORD_WIDTH,
	parameter int PARAM_FRACTION_BITS = HCPG_PARAM_FRACTION_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    restart,
	// output channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [LANE_W-1:0] coord_x,
	output logic signed [LANE_W-1:0] coord_y,
	output logic signed [LANE_W-1:0] coord_z,
	output logic [IDX_W-1:0]        point_index,
	output logic                    last
);

	localparam int F     = PARAM_FRACTION_BITS;
	localparam int PW    = F + 1;                     // t, t2, t3 width (up to 1.0)
	localparam int BW    = PW + 3;                    // signed basis width
	localparam int TW    = BW + 2;                    // sum of four basis terms
	localparam int AW    = TW + LANE_W;               // coordinate accumulator
	localparam int RW    = AW - F;                    // rounded coordinate
	localparam int XW    = ((RW > COORD_WIDTH) ? RW : COORD_WIDTH) + 1;
	localparam int SUM_W = ((PW > STEP_W) ? PW : STEP_W) + 1;
	localparam int MAXC  = (PW > LANE_W) ? PW : LANE_W;
	localparam int CNT_W = $clog2(MAXC);

	localparam logic [PW-1:0]          P_ONE     = {1'b1, {F{1'b0}}};
	localparam logic [2*PW-1:0]        PROD_HALF = (2*PW)'(1) << (F - 1);
	localparam logic signed [AW-1:0]   ACC_HALF  = AW'(1) << (F - 1);
	localparam logic signed [XW-1:0]   SAT_HI    =
		XW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic signed [XW-1:0]   SAT_LO    = ~SAT_HI;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SQ    = 9'b000000010,
		S_T2    = 9'b000000100,
		S_CUBE  = 9'b000001000,
		S_T3    = 9'b000010000,
		S_BASIS = 9'b000100000,
		S_ACC   = 9'b001000000,
		S_ROUND = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	// control state
	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PW-1:0]        param_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 out_valid_q;

	// configuration registers
	logic [VEC_W-1:0]     vec_q [NUM_VECS];
	logic [NSEG_W-1:0]    nseg_q;
	logic [STEP_W-1:0]    step_q;

	// datapath registers
	logic [PW-1:0]            mcand_q;
	logic [2*PW-1:0]          prod_q;
	logic [PW-1:0]            t2_q;
	logic [PW-1:0]            t3_q;
	logic signed [BW-1:0]     b_q    [NUM_VECS];
	logic [LANE_W-1:0]        bits_q [NUM_VECS][NUM_LANES];
	logic signed [AW-1:0]     acc_q  [NUM_LANES];
	logic signed [RW-1:0]     rnd_q  [NUM_LANES];
	logic [IDX_W-1:0]         idx_q;
	logic                     last_q;
	logic signed [LANE_W-1:0] coord_q [NUM_LANES];
	logic [IDX_W-1:0]         out_idx_q;
	logic                     out_last_q;

	// combinational
	logic                     in_fire;
	logic                     curve_done;
	logic                     out_load;
	logic [PW:0]              msum;
	logic [2*PW-1:0]          prod_rnd;
	logic [PW-1:0]            prod_t;
	logic [SUM_W-1:0]         param_nxt;
	logic signed [BW-1:0]     t1e, t2e, t3e, onee;
	logic signed [BW-1:0]     basis [NUM_VECS];
	logic signed [TW-1:0]     term [NUM_LANES];
	logic signed [AW-1:0]     acc_add [NUM_LANES];
	logic signed [AW-1:0]     acc_rnd [NUM_LANES];
	logic signed [XW-1:0]     sat_ext [NUM_LANES];
	logic signed [XW-1:0]     sat_val [NUM_LANES];

	// handshake
	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign curve_done = (count_q > {1'b0, nseg_q});
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// shared bit-serial multiplier step and product rounding
	assign msum     = {1'b0, prod_q[2*PW-1:PW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
	assign prod_rnd = prod_q + PROD_HALF;
	assign prod_t   = prod_rnd[F +: PW];

	// next curve parameter, before the clamp at 1.0
	assign param_nxt = SUM_W'(param_q) + SUM_W'(step_q);

	// Hermite basis from t, t2, t3
	always_comb begin
		t1e = BW'(mcand_q);
		t2e = BW'(t2_q);
		t3e = BW'(t3_q);
		onee = BW'(P_ONE);
		basis[0] = (t3e + t3e) - (t2e + t2e + t2e) + onee;
		basis[1] = (t2e + t2e + t2e) - (t3e + t3e);
		basis[2] = t3e - (t2e + t2e) + t1e;
		basis[3] = t3e - t2e;
	end

	// per-lane sum of basis values selected by the current coordinate bits
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			term[l] = '0;
			for (int k = 0; k < NUM_VECS; k++) begin
				if (bits_q[k][l][LANE_W-1]) begin
					term[l] = term[l] + TW'(b_q[k]);
				end
			end
			// sign bit of the coordinate carries negative weight
			acc_add[l] = (cnt_q == '0) ? -AW'(term[l]) : AW'(term[l]);
			acc_rnd[l] = acc_q[l] + ACC_HALF;
			sat_ext[l] = XW'(rnd_q[l]);
			if (sat_ext[l] > SAT_HI) begin
				sat_val[l] = SAT_HI;
			end else if (sat_ext[l] < SAT_LO) begin
				sat_val[l] = SAT_LO;
			end else begin
				sat_val[l] = sat_ext[l];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_VECS; k++) begin
				vec_q[k] <= '0;
			end
			nseg_q <= NSEG_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_START_POINT:   vec_q[0] <= cfg_data[VEC_W-1:0];
				REG_END_POINT:     vec_q[1] <= cfg_data[VEC_W-1:0];
				REG_START_TANGENT: vec_q[2] <= cfg_data[VEC_W-1:0];
				REG_END_TANGENT:   vec_q[3] <= cfg_data[VEC_W-1:0];
				REG_NUM_SEGMENTS:  nseg_q   <= cfg_data[NSEG_W-1:0];
				REG_T_STEP:        step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, curve state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			param_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (restart) begin
							param_q <= '0;
							count_q <= '0;
						end else if (!curve_done) begin
							param_q <= (param_nxt > SUM_W'(P_ONE)) ? P_ONE : param_nxt[PW-1:0];
							count_q <= count_q + COUNT_W'(1);
							cnt_q   <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PW - 1)) begin
						state_q <= S_T2;
					end
				end
				S_T2: begin
					cnt_q   <= '0;
					state_q <= S_CUBE;
				end
				S_CUBE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PW - 1)) begin
						state_q <= S_T3;
					end
				end
				S_T3: begin
					state_q <= S_BASIS;
				end
				S_BASIS: begin
					cnt_q   <= '0;
					state_q <= S_ACC;
				end
				S_ACC: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(LANE_W - 1)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: multiplier, basis, bit-serial accumulation, rounding
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mcand_q <= param_q;
			prod_q  <= {{PW{1'b0}}, param_q};
			idx_q   <= count_q[IDX_W-1:0];
			last_q  <= (count_q == {1'b0, nseg_q});
		end
		if ((state_q == S_SQ) || (state_q == S_CUBE)) begin
			prod_q <= {msum, prod_q[PW-1:1]};
		end
		if (state_q == S_T2) begin
			t2_q   <= prod_t;
			prod_q <= {{PW{1'b0}}, prod_t};
		end
		if (state_q == S_T3) begin
			t3_q <= prod_t;
		end
		if (state_q == S_BASIS) begin
			for (int k = 0; k < NUM_VECS; k++) begin
				b_q[k] <= basis[k];
				for (int l = 0; l < NUM_LANES; l++) begin
					bits_q[k][l] <= vec_q[k][l*LANE_W +: LANE_W];
				end
			end
			for (int l = 0; l < NUM_LANES; l++) begin
				acc_q[l] <= '0;
			end
		end
		if (state_q == S_ACC) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				acc_q[l] <= (acc_q[l] <<< 1) + acc_add[l];
				for (int k = 0; k < NUM_VECS; k++) begin
					bits_q[k][l] <= {bits_q[k][l][LANE_W-2:0], 1'b0};
				end
			end
		end
		if (state_q == S_ROUND) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				rnd_q[l] <= acc_rnd[l][AW-1:F];
			end
		end
		if (out_load) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				coord_q[l] <= sat_val[l][LANE_W-1:0];
			end
			out_idx_q  <= idx_q;
			out_last_q <= last_q;
		end
	end

	// outputs
	assign out_valid   = out_valid_q;
	assign coord_x     = coord_q[0];
	assign coord_y     = coord_q[1];
	assign coord_z     = coord_q[2];
	assign point_index = out_idx_q;
	assign last        = out_last_q;

	// checks
	`HCPG_ASSERT_IMP(a_param_bound, 1'b1, param_q <= P_ONE, "curve parameter above one")
	`HCPG_ASSERT_IMP(a_t2_bound, state_q == S_CUBE, t2_q <= P_ONE, "t squared above one")
	`HCPG_ASSERT_IMP(a_last_index, out_valid_q && out_last_q, out_idx_q == nseg_q, "last flag on wrong index")
	`HCPG_ASSERT_NXT(a_load_valid, out_load, out_valid_q, "loaded point not presented")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Hermite curve point generator: corners, random and long curves.
`timescale 1ns / 1ps

module testbench;
	import hcpg_pkg::*;

	localparam int     CYCLE_LIMIT   = 1_000_000;
	localparam int     SETTLE_CYCLES = 64;     // wait before each reconfiguration
	localparam int     RANDOM_ITEMS  = 200;
	localparam int     REPORT_MAX    = 10;
	localparam int     FRAC          = HCPG_PARAM_FRACTION_BITS;
	localparam longint PARAM_ONE     = longint'(1) << FRAC;
	localparam longint PARAM_HALF    = longint'(1) << (FRAC - 1);
	localparam longint COORD_MAX     = (longint'(1) << (HCPG_COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN     = -COORD_MAX - 1;

	// Indexes past the register map; writes there must be dropped
	localparam cfg_idx_t REG_SPARE_6 = 3'd6;
	localparam cfg_idx_t REG_SPARE_7 = 3'd7;

	localparam logic [VEC_W-1:0] VEC_MAX = {NUM_LANES{16'h7FFF}};
	localparam logic [VEC_W-1:0] VEC_MIN = {NUM_LANES{16'h8000}};

	typedef struct packed {
		logic signed [LANE_W-1:0] x;
		logic signed [LANE_W-1:0] y;
		logic signed [LANE_W-1:0] z;
		logic [IDX_W-1:0]         idx;
		logic                     last;
	} curve_point_t;

	typedef enum int {TXN_RESTART, TXN_POINT, TXN_IGNORED} txn_kind_t;

	// Curve state mirror plus queue of points still owed by the block
	class curve_scoreboard;
		logic [VEC_W-1:0]   ctrl_vec[NUM_VECS];   // P0, P1, T0, T1
		logic [NSEG_W-1:0]  num_segments;
		logic [STEP_W-1:0]  t_step;
		logic [COUNT_W-1:0] point_count;
		longint             curve_param;
		curve_point_t       expected_points[$];
		int                 mismatches;
		int                 points_checked;
		int                 restarts_seen;
		int                 ignored_ticks;

		function new();
			foreach (ctrl_vec[i])
				ctrl_vec[i] = '0;
			num_segments   = NSEG_RESET;
			t_step         = STEP_RESET;
			point_count    = '0;
			curve_param    = 0;
			mismatches     = 0;
			points_checked = 0;
			restarts_seen  = 0;
			ignored_ticks  = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_START_POINT:   ctrl_vec[0] = data[VEC_W-1:0];
				REG_END_POINT:     ctrl_vec[1] = data[VEC_W-1:0];
				REG_START_TANGENT: ctrl_vec[2] = data[VEC_W-1:0];
				REG_END_TANGENT:   ctrl_vec[3] = data[VEC_W-1:0];
				REG_NUM_SEGMENTS:  num_segments = data[NSEG_W-1:0];
				REG_T_STEP:        t_step = data[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		// Hermite basis at the current t, weighted sum per lane, round and saturate
		function curve_point_t predict_point();
			longint       t, t2, t3, sum, rounded;
			longint       basis[NUM_VECS];
			logic [15:0]  lane_val[NUM_LANES];
			curve_point_t pt;
			t  = curve_param;
			t2 = (t * t + PARAM_HALF) >> FRAC;
			t3 = (t2 * t + PARAM_HALF) >> FRAC;
			basis[0] = 2 * t3 - 3 * t2 + PARAM_ONE;
			basis[1] = 3 * t2 - 2 * t3;
			basis[2] = t3 - 2 * t2 + t;
			basis[3] = t3 - t2;
			for (int lane = 0; lane < NUM_LANES; lane++) begin
				sum = 0;
				for (int v = 0; v < NUM_VECS; v++)
					sum += basis[v] * longint'($signed(ctrl_vec[v][lane*LANE_W +: LANE_W]));
				// arithmetic shift gives floor, so half rounds toward +inf
				rounded = (sum + PARAM_HALF) >>> FRAC;
				if (rounded > COORD_MAX)
					rounded = COORD_MAX;
				if (rounded < COORD_MIN)
					rounded = COORD_MIN;
				lane_val[lane] = rounded[15:0];
			end
			pt.x    = lane_val[0];
			pt.y    = lane_val[1];
			pt.z    = lane_val[2];
			pt.idx  = point_count[IDX_W-1:0];
			pt.last = (point_count == COUNT_W'(num_segments));
			return pt;
		endfunction

		// Called once per accepted input transaction
		function txn_kind_t note_transaction(logic rs);
			longint next_param;
			if (rs) begin
				point_count = '0;
				curve_param = 0;
				restarts_seen++;
				return TXN_RESTART;
			end
			// curve finished: tick is dropped, state untouched
			if (point_count > COUNT_W'(num_segments)) begin
				ignored_ticks++;
				return TXN_IGNORED;
			end
			expected_points.push_back(predict_point());
			next_param  = curve_param + longint'(t_step);
			curve_param = (next_param > PARAM_ONE) ? PARAM_ONE : next_param;
			point_count = point_count + COUNT_W'(1);
			return TXN_POINT;
		endfunction

		// Called once per accepted output transaction
		function void check_point(curve_point_t got);
			curve_point_t want;
			bit           bad;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: unexpected point idx=%0d x=%0d y=%0d z=%0d last=%0b",
						got.idx, $signed(got.x), $signed(got.y), $signed(got.z), got.last);
				return;
			end
			want = expected_points.pop_front();
			points_checked++;
			bad = (got.x !== want.x) || (got.y !== want.y) || (got.z !== want.z) ||
				(got.idx !== want.idx) || (got.last !== want.last);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("ERROR: point mismatch, expected idx=%0d x=%0d y=%0d z=%0d last=%0b",
						want.idx, $signed(want.x), $signed(want.y), $signed(want.z), want.last);
					$display("       actual            idx=%0d x=%0d y=%0d z=%0d last=%0b",
						got.idx, $signed(got.x), $signed(got.y), $signed(got.z), got.last);
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   restart;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [LANE_W-1:0] coord_x;
	logic signed [LANE_W-1:0] coord_y;
	logic signed [LANE_W-1:0] coord_z;
	logic [IDX_W-1:0]       point_index;
	logic                   last;

	curve_scoreboard sb;
	bit              tx_idle_en;
	bit              rx_idle_en;
	int              cycle_count = 0;
	int              settings_used = 0;

	hermite_curve_point_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.point_index(point_index),
		.last       (last)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d points outstanding",
				cycle_count, sb.expected_points.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output side: sample at rising edge, random back-pressure after each transaction
	initial begin : point_sink
		int           stall;
		curve_point_t got;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.x    = coord_x;
				got.y    = coord_y;
				got.z    = coord_z;
				got.idx  = point_index;
				got.last = last;
				sb.check_point(got);
				stall = rx_idle_en ? $urandom_range(0, 15) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Drive one input transaction and wait for it to be taken
	task automatic send_item(input logic rs, output txn_kind_t kind);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do
			@(posedge clk);
		while (!in_ready);
		kind = sb.note_transaction(rs);
	endtask

	// Hold off the input until every owed point has come out
	task automatic drain_points();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_word();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Narrow registers get random junk above the field now and then
	function automatic logic [CFG_DATA_W-1:0] pad_field(input logic [STEP_W-1:0] val,
			input int width);
		logic [CFG_DATA_W-1:0] d;
		d = ($urandom_range(0, 1) == 0) ? '0 : rand_word();
		for (int i = 0; i < width; i++)
			d[i] = val[i];
		return d;
	endfunction

	task automatic configure(input logic [VEC_W-1:0] p0, input logic [VEC_W-1:0] p1,
			input logic [VEC_W-1:0] t0, input logic [VEC_W-1:0] t1,
			input logic [NSEG_W-1:0] nseg, input logic [STEP_W-1:0] step);
		write_reg(REG_START_POINT, p0);
		write_reg(REG_END_POINT, p1);
		write_reg(REG_START_TANGENT, t0);
		write_reg(REG_END_TANGENT, t1);
		write_reg(REG_NUM_SEGMENTS, pad_field(STEP_W'(nseg), NSEG_W));
		write_reg(REG_T_STEP, pad_field(step, STEP_W));
		settings_used++;
	endtask

	function automatic logic [LANE_W-1:0] rand_lane();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 2047)) - 16'd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [VEC_W-1:0] rand_vector();
		return {rand_lane(), rand_lane(), rand_lane()};
	endfunction

	function automatic logic [NSEG_W-1:0] pick_segments();
		return ($urandom_range(0, 4) == 0) ? NSEG_W'($urandom_range(0, 40))
			: NSEG_W'($urandom_range(0, 12));
	endfunction

	// Half the time a step that lands near t = 1 at the last point; corners or a random step otherwise
	function automatic logic [STEP_W-1:0] pick_step(input logic [NSEG_W-1:0] nseg);
		int nominal;
		nominal = (nseg == 0) ? 65536 : 65536 / int'(nseg);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return STEP_W'(1);
			2: return '1;
			3: return STEP_W'(65536);
			4: return STEP_W'($urandom_range(0, 131071));
			default: return STEP_W'(nominal + $urandom_range(0, 64) - 32);
		endcase
	endfunction

	initial begin : stimulus
		txn_kind_t         kind;
		int                random_sent;
		int                n_ticks;
		logic [NSEG_W-1:0] nseg;
		logic [STEP_W-1:0] step;
		logic              rs;

		sb          = new();
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		restart     = 1'b0;
		out_ready   = 1'b0;
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		random_sent = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero vectors, 50 segments, default step
		send_item(1'b0, kind);
		send_item(1'b0, kind);
		send_item(1'b1, kind);

		// Single-point curve, positive extremes against negative, step overflows
		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);
		configure(VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, '0, '1);
		send_item(1'b0, kind);
		send_item(1'b0, kind);
		send_item(1'b1, kind);
		send_item(1'b0, kind);

		// Step of exactly one: t hits 1.0 and then clamps
		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);
		configure(VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, NSEG_W'(3), STEP_W'(65536));
		send_item(1'b1, kind);
		repeat (5) send_item(1'b0, kind);

		// Zero step repeats the point; writes past the map are dropped
		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_START_POINT, rand_word());
		write_reg(REG_SPARE_6, rand_word());
		write_reg(REG_SPARE_7, rand_word());
		write_reg(REG_T_STEP, '0);
		write_reg(REG_NUM_SEGMENTS, CFG_DATA_W'(2));
		send_item(1'b1, kind);
		repeat (4) send_item(1'b0, kind);

		// Random curves, each under fresh settings
		while (random_sent < RANDOM_ITEMS) begin
			drain_points();
			repeat (SETTLE_CYCLES) @(posedge clk);
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			nseg = pick_segments();
			step = pick_step(nseg);
			configure(rand_vector(), rand_vector(), rand_vector(), rand_vector(), nseg, step);
			if ($urandom_range(0, 7) == 0)
				write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7, rand_word());
			send_item(1'b1, kind);
			random_sent++;
			n_ticks = int'(nseg) + 1 + $urandom_range(0, 3);
			for (int k = 0; k < n_ticks; k++) begin
				rs = ($urandom_range(0, 29) == 0);
				send_item(rs, kind);
				if (kind != TXN_IGNORED)
					random_sent++;
				// occasionally let the pipeline run dry mid-curve
				if ($urandom_range(0, 39) == 0)
					drain_points();
			end
		end

		// One full-length curve: 1024 points, t just under 1.0 at the end
		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		configure(rand_vector(), rand_vector(), rand_vector(), rand_vector(), '1, STEP_W'(64));
		send_item(1'b1, kind);
		repeat (1026) send_item(1'b0, kind);

		drain_points();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d curve points under %0d register settings.",
			sb.points_checked, settings_used);
		$display("Also drove %0d restarts and %0d ticks past the end of a curve.",
			sb.restarts_seen, sb.ignored_ticks);
		if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d points never seen",
				sb.mismatches, sb.expected_points.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
